// ----- rtl/core/psb_pkg.sv -----
// Shared types and constants for the paced parallel byte streamer.
// No dependencies; imported by both interfaces and by every module of the block but psb_ram.
package psb_pkg;

    localparam int PSB_QUEUE_DEPTH = 1024;

    localparam int PSB_PERIOD_W = 30;
    localparam int PSB_PINS_W   = 4;
    localparam int PSB_BYTE_W   = 8;
    localparam int PSB_FILL_W   = 10;
    localparam int PSB_CFG_W    = PSB_PERIOD_W;
    localparam int PSB_CFG_IDX_W = 1;

    localparam logic [PSB_PERIOD_W-1:0] PSB_PERIOD_RST = PSB_PERIOD_W'(1000000);

    // register indexes of the config port
    localparam logic [PSB_CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 1'b0;
    localparam logic [PSB_CFG_IDX_W-1:0] CFG_NUM_PINS      = 1'b1;

    // request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    typedef struct packed {
        logic [PSB_BYTE_W-1:0] pin_levels;
        logic                  sample_strobe;
        logic                  write_accepted;
        logic                  writer_held;
        logic [PSB_FILL_W-1:0] fill_count;
    } t_rsp;

endpackage

// ----- rtl/core/psb_in_if.sv -----
// Request channel: valid/ready handshake carrying one request word.
// Depends on psb_pkg for field widths.
interface psb_in_if import psb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [PSB_BYTE_W-1:0] write_byte;

    modport source (output valid, output req_type, output write_byte, input ready);
    modport sink   (input valid, input req_type, input write_byte, output ready);
endinterface

// ----- rtl/core/psb_out_if.sv -----
// Result channel: valid/ready handshake carrying one result word.
// Depends on psb_pkg for field widths.
interface psb_out_if import psb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [PSB_BYTE_W-1:0] pin_levels;
    logic                  sample_strobe;
    logic                  write_accepted;
    logic                  writer_held;
    logic [PSB_FILL_W-1:0] fill_count;

    modport source (output valid, output pin_levels, output sample_strobe,
                    output write_accepted, output writer_held, output fill_count,
                    input ready);
    modport sink   (input valid, input pin_levels, input sample_strobe,
                    input write_accepted, input writer_held, input fill_count,
                    output ready);
endinterface

// ----- rtl/core/psb_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module psb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/psb_skid.sv -----
// Two-word output buffer: main register plus skid register.
// Depends on psb_pkg (t_rsp) and psb_out_if.
module psb_skid import psb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_rsp     i_data,
    psb_out_if.source o_out
);

    logic r_main_v, n_main_v;
    logic r_skid_v, n_skid_v;
    t_rsp r_main, n_main;
    t_rsp r_skid, n_skid;
    logic pop;

    assign o_ready = !r_skid_v;
    assign pop     = r_main_v && o_out.ready;

    always_comb begin
        n_main_v = r_main_v;
        n_skid_v = r_skid_v;
        n_main   = r_main;
        n_skid   = r_skid;
        if (r_skid_v) begin
            if (pop) begin
                n_main   = r_skid;
                n_skid_v = 1'b0;
            end
        end else if (i_valid) begin
            if (!r_main_v || pop) begin
                n_main   = i_data;
                n_main_v = 1'b1;
            end else begin
                n_skid   = i_data;
                n_skid_v = 1'b1;
            end
        end else if (pop) begin
            n_main_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_main_v <= n_main_v;
            r_skid_v <= n_skid_v;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_out.valid          = r_main_v;
    assign o_out.pin_levels     = r_main.pin_levels;
    assign o_out.sample_strobe  = r_main.sample_strobe;
    assign o_out.write_accepted = r_main.write_accepted;
    assign o_out.writer_held    = r_main.writer_held;
    assign o_out.fill_count     = r_main.fill_count;

endmodule

// ----- rtl/core/paced_parallel_byte_streamer.sv -----
// Paced parallel byte streamer: byte queue in RAM drained to a pin word.
// Depends on psb_pkg, psb_in_if, psb_out_if, psb_ram and psb_skid.
//
// Use:
//  - i_in carries request words: req_type 0 queues write_byte, req_type 1
//    is one time tick. Every request word yields exactly one result word
//    on o_out: pin levels, sample strobe, write accepted, held flag and
//    the queue fill after the request (saturated at 1023).
//  - Config port (i_cfg_we/i_cfg_idx/i_cfg_data): index 0 is the sample
//    period in ticks, index 1 the number of driven pins. Write only while idle.
//  - Throughput: one request word per cycle while the receiver keeps up. Each
//    result word is registered in the output buffer before it shows on o_out.
//  - The queue lives in one RAM with a registered read. Its read
//    port always prefetches the entry at the read index, so a sample tick
//    finds its byte ready; the write pointer never equals the read pointer,
//    so no read/write clash needs forwarding.
//  - Reset: one zero byte queued (write index 1, read index 0), period
//    counter, pins and held flag cleared. Entry zero reads as zero until it
//    is first written; no clearing pass is needed.
//  - Receiver stall: a two-word output buffer keeps taking requests until
//    both words are full, then i_in.ready drops; nothing is lost.
module paced_parallel_byte_streamer import psb_pkg::*; #(
    parameter int QUEUE_DEPTH = PSB_QUEUE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    psb_in_if.sink                   i_in,
    psb_out_if.source                o_out,
    input  logic                     i_cfg_we,
    input  logic [PSB_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PSB_CFG_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int FW = (AW > PSB_FILL_W) ? AW : PSB_FILL_W;
    localparam int THREE_QTR = (3 * QUEUE_DEPTH) / 4;

    // queue pointers and fill
    logic [AW-1:0] r_wr_idx, n_wr_idx;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [AW-1:0] r_fill,   n_fill;
    // pacing and outputs
    logic [PSB_PERIOD_W-1:0] r_period_cnt, n_period_cnt;
    logic [PSB_BYTE_W-1:0]   r_levels, n_levels;
    logic                    r_hold, n_hold;
    // entry zero reads as zero until first written
    logic                    r_zero_valid, n_zero_valid;
    logic                    r_rd_blank;
    // config
    logic [PSB_PERIOD_W-1:0] r_sample_period;
    logic [PSB_PINS_W-1:0]   r_num_pins;

    logic                    accept, is_wr, is_tick, wr_ok, do_write;
    logic                    do_sample, advance;
    logic [PSB_PERIOD_W-1:0] period_eff, cnt_inc;
    logic [PSB_BYTE_W-1:0]   ram_rdata, cur_byte, pin_mask;
    logic [FW-1:0]           fill_ext;
    logic                    skid_ready;
    t_rsp                    rsp;

    assign accept   = i_in.valid && i_in.ready;
    assign is_wr    = accept && (i_in.req_type == REQ_WRITE);
    assign is_tick  = accept && (i_in.req_type == REQ_TICK);
    assign wr_ok    = !r_hold && (r_fill < AW'(QUEUE_DEPTH - 1));
    assign do_write = is_wr && wr_ok;

    // period of zero acts as one; counter wraps at 30 bits
    assign period_eff = (r_sample_period == '0) ? PSB_PERIOD_W'(1) : r_sample_period;
    assign cnt_inc    = r_period_cnt + PSB_PERIOD_W'(1);
    assign do_sample  = is_tick && (cnt_inc >= period_eff);
    // last byte repeats: keep pointer when only one byte left
    assign advance    = do_sample && (r_fill > AW'(1));

    assign cur_byte = r_rd_blank ? '0 : ram_rdata;
    assign pin_mask = (r_num_pins >= PSB_PINS_W'(PSB_BYTE_W)) ? '1
                    : PSB_BYTE_W'((9'd1 << r_num_pins) - 9'd1);

    always_comb begin
        n_wr_idx     = r_wr_idx;
        n_rd_idx     = r_rd_idx;
        n_fill       = r_fill;
        n_period_cnt = r_period_cnt;
        n_levels     = r_levels;
        n_hold       = r_hold;
        n_zero_valid = r_zero_valid;
        if (is_wr) begin
            if (wr_ok) begin
                n_wr_idx = (r_wr_idx == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_idx + AW'(1);
                n_fill   = r_fill + AW'(1);
                if (r_wr_idx == '0) begin
                    n_zero_valid = 1'b1;
                end
            end else begin
                n_hold = 1'b1;
            end
        end
        if (is_tick) begin
            if (do_sample) begin
                n_period_cnt = '0;
                n_levels     = (r_levels & ~pin_mask) | (cur_byte & pin_mask);
                if (advance) begin
                    n_rd_idx = (r_rd_idx == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_idx + AW'(1);
                    n_fill   = r_fill - AW'(1);
                end
                // release judged on the fill before the advance
                if (r_fill < AW'(THREE_QTR)) begin
                    n_hold = 1'b0;
                end
            end else begin
                n_period_cnt = cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx        <= AW'(1);
            r_rd_idx        <= '0;
            r_fill          <= AW'(1);
            r_period_cnt    <= '0;
            r_levels        <= '0;
            r_hold          <= 1'b0;
            r_zero_valid    <= 1'b0;
            r_rd_blank      <= 1'b1;
            r_sample_period <= PSB_PERIOD_RST;
            r_num_pins      <= '0;
        end else begin
            r_wr_idx     <= n_wr_idx;
            r_rd_idx     <= n_rd_idx;
            r_fill       <= n_fill;
            r_period_cnt <= n_period_cnt;
            r_levels     <= n_levels;
            r_hold       <= n_hold;
            r_zero_valid <= n_zero_valid;
            // tracks the prefetch issued this cycle
            r_rd_blank   <= (n_rd_idx == '0) && !n_zero_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SAMPLE_PERIOD: r_sample_period <= i_cfg_data[PSB_PERIOD_W-1:0];
                    CFG_NUM_PINS:      r_num_pins      <= i_cfg_data[PSB_PINS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // queue store; read port prefetches the next read index
    psb_ram #(
        .WIDTH (PSB_BYTE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (r_wr_idx),
        .i_wdata (i_in.write_byte),
        .i_raddr (n_rd_idx),
        .o_rdata (ram_rdata)
    );

    assign fill_ext = FW'(n_fill);

    always_comb begin
        rsp.pin_levels     = n_levels;
        rsp.sample_strobe  = do_sample;
        rsp.write_accepted = do_write;
        rsp.writer_held    = n_hold;
        rsp.fill_count     = (fill_ext > FW'(1023)) ? PSB_FILL_W'(1023)
                                                    : fill_ext[PSB_FILL_W-1:0];
    end

    psb_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .o_ready (skid_ready),
        .i_data  (rsp),
        .o_out   (o_out)
    );

    assign i_in.ready = skid_ready;

endmodule

// ----- rtl/core/psb_checker.sv -----
// Port-level checks for the paced parallel byte streamer, bound to the top.
// Depends on psb_pkg for widths.
module psb_checker import psb_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic                  i_sample_strobe,
    input logic                  i_write_accepted,
    input logic                  i_writer_held,
    input logic [PSB_FILL_W-1:0] i_fill_count
);

    // a pending result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // requests are only refused when results are backed up
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("request stalled with empty output");

    // a word is never both a sample and a write
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_sample_strobe && i_write_accepted))
        else $error("sample and write in one word");

    // a stored write means the writer is not held, and the queue is not empty
    a_accept_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_write_accepted |-> !i_writer_held && (i_fill_count != '0))
        else $error("write stored while held");

endmodule

bind paced_parallel_byte_streamer psb_checker u_psb_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_sample_strobe  (o_out.sample_strobe),
    .i_write_accepted (o_out.write_accepted),
    .i_writer_held    (o_out.writer_held),
    .i_fill_count     (o_out.fill_count)
);

// ----- bench/tb.sv -----
// Self-checking bench for paced_parallel_byte_streamer: bursty request words,
// a stalling result sink and a scoreboard class that predicts every result.
// Depends on psb_pkg, psb_in_if, psb_out_if and the block itself.
module tb;
    import psb_pkg::*;

    // Scoreboard: own copy of the queue, pointers, period counter and pins,
    // stepped once per accepted request word.
    class pin_stream_tracker;
        logic [PSB_BYTE_W-1:0]   byte_store [PSB_QUEUE_DEPTH];
        int unsigned             wr_idx;
        int unsigned             rd_idx;
        logic [PSB_PERIOD_W-1:0] tick_count;
        logic [PSB_PERIOD_W-1:0] period_reg;
        logic [PSB_PINS_W-1:0]   pins_reg;
        logic [PSB_BYTE_W-1:0]   levels;
        logic                    held;
        t_rsp                    pending_results [$];
        int unsigned             mismatches;

        function new();
            foreach (byte_store[i]) byte_store[i] = '0;
            wr_idx     = 1 % PSB_QUEUE_DEPTH;
            rd_idx     = 0;
            tick_count = '0;
            period_reg = PSB_PERIOD_RST;
            pins_reg   = '0;
            levels     = '0;
            held       = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [PSB_CFG_IDX_W-1:0] idx, logic [PSB_CFG_W-1:0] data);
            if (idx == CFG_SAMPLE_PERIOD) begin
                period_reg = data[PSB_PERIOD_W-1:0];
            end else begin
                pins_reg = data[PSB_PINS_W-1:0];
            end
        endfunction

        function int unsigned fill_now();
            return (wr_idx + PSB_QUEUE_DEPTH - rd_idx) % PSB_QUEUE_DEPTH;
        endfunction

        function void take_request(logic kind, logic [PSB_BYTE_W-1:0] data);
            t_rsp                    want;
            logic [PSB_PERIOD_W-1:0] period;
            logic [PSB_PERIOD_W-1:0] nxt;
            int unsigned             pins;
            int unsigned             left;
            logic [PSB_BYTE_W:0]     wide_mask;
            logic [PSB_BYTE_W-1:0]   mask;
            int unsigned             fill;
            want = '0;
            if (kind == REQ_WRITE) begin
                if (!held && fill_now() < PSB_QUEUE_DEPTH - 1) begin
                    byte_store[wr_idx] = data;
                    wr_idx = (wr_idx + 1) % PSB_QUEUE_DEPTH;
                    want.write_accepted = 1'b1;
                end else begin
                    held = 1'b1;
                end
            end else begin
                // period of zero acts as one
                period = (period_reg == '0) ? PSB_PERIOD_W'(1) : period_reg;
                nxt = tick_count + 1'b1;
                if (nxt >= period) begin
                    tick_count = '0;
                    pins = (pins_reg > 8) ? 8 : pins_reg;
                    wide_mask = (9'd1 << pins) - 9'd1;
                    mask = wide_mask[PSB_BYTE_W-1:0];
                    left = fill_now();
                    levels = (levels & ~mask) | (byte_store[rd_idx] & mask);
                    // last byte repeats
                    if (left > 1) rd_idx = (rd_idx + 1) % PSB_QUEUE_DEPTH;
                    if (held && left < (3 * PSB_QUEUE_DEPTH) / 4) held = 1'b0;
                    want.sample_strobe = 1'b1;
                end else begin
                    tick_count = nxt;
                end
            end
            fill = fill_now();
            if (fill > 1023) fill = 1023;
            want.pin_levels  = levels;
            want.writer_held = held;
            want.fill_count  = fill[PSB_FILL_W-1:0];
            pending_results.push_back(want);
        endfunction

        function void match_result(t_rsp got);
            t_rsp want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: pins %02h strobe %0d acc %0d held %0d fill %0d",
                             got.pin_levels, got.sample_strobe, got.write_accepted,
                             got.writer_held, got.fill_count);
                return;
            end
            want = pending_results.pop_front();
            if (got.pin_levels !== want.pin_levels || got.sample_strobe !== want.sample_strobe
                || got.write_accepted !== want.write_accepted
                || got.writer_held !== want.writer_held || got.fill_count !== want.fill_count) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: want pins %02h strobe %0d acc %0d held %0d fill %0d",
                             want.pin_levels, want.sample_strobe, want.write_accepted,
                             want.writer_held, want.fill_count);
                    $display("          got  pins %02h strobe %0d acc %0d held %0d fill %0d",
                             got.pin_levels, got.sample_strobe, got.write_accepted,
                             got.writer_held, got.fill_count);
                end
            end
        endfunction
    endclass

    typedef enum {RX_FREE, RX_HALF, RX_MOSTLY, RX_EVERY_FOURTH} t_rx_mode;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     cfg_we;
    logic [PSB_CFG_IDX_W-1:0] cfg_idx;
    logic [PSB_CFG_W-1:0]     cfg_data;

    psb_in_if  in_if ();
    psb_out_if out_if ();

    pin_stream_tracker tracker;

    // sender burst state
    int  burst_left = 0;
    int  random_items = 0;
    // long hold-off requests from the stimulus, and how many the sink has served
    int       long_stall_req = 0;
    int       long_stall_done = 0;
    // receiver state
    int       hold_left = 0;
    int       mode_left = 0;
    int       phase_cnt = 0;
    t_rx_mode rx_mode = RX_FREE;
    t_rsp     seen;

    paced_parallel_byte_streamer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // Result sink. Checks each accepted word, then picks the next ready level:
    // a long hold-off when asked for, otherwise a stall mode picked anew at
    // random intervals (free running, half, mostly ready, every fourth).
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                seen.pin_levels     = out_if.pin_levels;
                seen.sample_strobe  = out_if.sample_strobe;
                seen.write_accepted = out_if.write_accepted;
                seen.writer_held    = out_if.writer_held;
                seen.fill_count     = out_if.fill_count;
                tracker.match_result(seen);
            end
            if (long_stall_done != long_stall_req) begin
                hold_left = 300;
                long_stall_done = long_stall_req;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 120);
                end
                mode_left--;
                phase_cnt++;
                case (rx_mode)
                    RX_FREE:         out_if.ready <= 1'b1;
                    RX_HALF:         out_if.ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY:       out_if.ready <= ($urandom_range(0, 4) != 0);
                    RX_EVERY_FOURTH: out_if.ready <= (phase_cnt % 4 == 0);
                    default:         out_if.ready <= 1'b1;
                endcase
            end
        end
    end

    // Offer one request word and hold it until taken. Called just after a
    // rising edge. Between bursts valid drops and stays low over a random gap,
    // so it is never lowered and raised in the same step.
    task automatic send_word(input logic kind, input logic [PSB_BYTE_W-1:0] data);
        int gap;
        if (burst_left == 0) begin
            in_if.valid <= 1'b0;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 25);
        end
        in_if.valid      <= 1'b1;
        in_if.req_type   <= kind;
        in_if.write_byte <= data;
        do @(posedge i_clk); while (!in_if.ready);
        tracker.take_request(kind, data);
        burst_left--;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_word(REQ_TICK, PSB_BYTE_W'($urandom_range(0, 255)));
    endtask

    // Drop valid and wait for every outstanding result before returning.
    task automatic settle();
        int n;
        n = 0;
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (tracker.pending_results.size() != 0 && n < 20000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Register write, only ever issued with the block idle.
    task automatic write_reg(input logic [PSB_CFG_IDX_W-1:0] idx,
                             input logic [PSB_CFG_W-1:0] data);
        settle();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        tracker.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    initial begin
        int len;
        int tick_pct;
        int pick;
        tracker = new();
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.req_type   = REQ_WRITE;
        in_if.write_byte = '0;
        out_if.ready     = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = CFG_SAMPLE_PERIOD;
        cfg_data         = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part ---
        // reset period is far off: ticks only count
        send_ticks(2);
        write_reg(CFG_SAMPLE_PERIOD, PSB_CFG_W'(1));
        write_reg(CFG_NUM_PINS, PSB_CFG_W'(8));
        // sample of the lone zero byte queued at reset
        send_ticks(1);
        send_word(REQ_WRITE, 8'hFF);
        send_word(REQ_WRITE, 8'h00);
        send_word(REQ_WRITE, 8'hA5);
        send_word(REQ_WRITE, 8'h5A);
        // drain, then the last byte repeats
        send_ticks(5);
        // no pins driven: strobe only
        write_reg(CFG_NUM_PINS, PSB_CFG_W'(0));
        send_word(REQ_WRITE, 8'h3C);
        send_ticks(1);
        // pin count above eight
        write_reg(CFG_NUM_PINS, PSB_CFG_W'(15));
        send_ticks(1);
        // partial pin count keeps the upper bits
        write_reg(CFG_NUM_PINS, PSB_CFG_W'(3));
        send_word(REQ_WRITE, 8'hFF);
        send_ticks(1);
        // zero period
        write_reg(CFG_SAMPLE_PERIOD, PSB_CFG_W'(0));
        send_ticks(2);
        // period lowered below the running count
        write_reg(CFG_SAMPLE_PERIOD, PSB_CFG_W'(10));
        send_ticks(5);
        write_reg(CFG_SAMPLE_PERIOD, PSB_CFG_W'(3));
        send_ticks(1);
        write_reg(CFG_SAMPLE_PERIOD, PSB_CFG_W'(1000000000));
        send_ticks(2);

        // --- fill to full, refused writes set the hold, writes while held ---
        write_reg(CFG_SAMPLE_PERIOD, PSB_CFG_W'(1000000));
        write_reg(CFG_NUM_PINS, PSB_CFG_W'(8));
        long_stall_req++;
        repeat (1026) send_word(REQ_WRITE, PSB_BYTE_W'($urandom_range(0, 255)));

        // --- drain below three quarters with writes mixed in ---
        write_reg(CFG_SAMPLE_PERIOD, PSB_CFG_W'(1));
        write_reg(CFG_NUM_PINS, PSB_CFG_W'($urandom_range(0, 15)));
        send_ticks(250);
        repeat (40) begin
            if ($urandom_range(0, 99) < 80) send_ticks(1);
            else send_word(REQ_WRITE, PSB_BYTE_W'($urandom_range(0, 255)));
        end

        // --- random phases with fresh settings each ---
        while (random_items < 40) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       write_reg(CFG_SAMPLE_PERIOD, PSB_CFG_W'(0));
                7:       write_reg(CFG_SAMPLE_PERIOD, PSB_CFG_W'($urandom_range(5, 20)));
                8:       write_reg(CFG_SAMPLE_PERIOD, PSB_CFG_W'(($urandom_range(0, 1) == 0)
                                   ? 1000000000 : $urandom_range(21, 1000000000)));
                9:       write_reg(CFG_SAMPLE_PERIOD, PSB_CFG_W'(1));
                default: write_reg(CFG_SAMPLE_PERIOD, PSB_CFG_W'($urandom_range(1, 4)));
            endcase
            write_reg(CFG_NUM_PINS, PSB_CFG_W'($urandom_range(0, 15)));
            case ($urandom_range(0, 4))
                0:       tick_pct = 5;
                1:       tick_pct = 30;
                2:       tick_pct = 50;
                3:       tick_pct = 70;
                default: tick_pct = 95;
            endcase
            if (random_items == 0) long_stall_req++;
            len = $urandom_range(20, 80);
            repeat (len) begin
                if ($urandom_range(0, 99) < tick_pct) send_ticks(1);
                else send_word(REQ_WRITE, PSB_BYTE_W'($urandom_range(0, 255)));
                random_items++;
            end
        end

        // --- wind down ---
        settle();
        if (tracker.pending_results.size() != 0) begin
            $display("%0d result words never arrived", tracker.pending_results.size());
            tracker.mismatches += tracker.pending_results.size();
        end
        if (tracker.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/psb_pkg.sv
rtl/core/psb_in_if.sv
rtl/core/psb_out_if.sv
rtl/core/psb_ram.sv
rtl/core/psb_skid.sv
rtl/core/paced_parallel_byte_streamer.sv
rtl/core/psb_checker.sv
bench/tb.sv
